@@ rtl/double_ended_stack_allocator_assert.svh @@
// Assertion macros for the double-ended stack allocator.
// No dependencies; taken in by the modules that carry assertions.
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_ASSERT_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define DESA_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("allocator assertion failed");

// next-cycle implication
`define DESA_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("allocator assertion failed");

`endif

@@ rtl/desa_pkg.sv @@
// Package of the double-ended stack allocator: widths, codes and the
// controller-to-datapath command type. No dependencies.
package desa_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 64;

    localparam int FW = 17;   // address/size field width
    localparam int WW = 19;   // internal arithmetic width
    localparam int KW = 3;
    localparam int AW = 4;
    localparam int SW = 2;

    typedef logic [KW-1:0] kind_t;
    typedef logic [SW-1:0] status_t;

    localparam kind_t KIND_ALLOC_BOTTOM = 3'd0;
    localparam kind_t KIND_ALLOC_TOP    = 3'd1;
    localparam kind_t KIND_FREE_BOTTOM  = 3'd2;
    localparam kind_t KIND_FREE_TOP     = 3'd3;
    localparam kind_t KIND_RESET_BOTTOM = 3'd4;
    localparam kind_t KIND_RESET_TOP    = 3'd5;
    localparam kind_t KIND_RESET_BOTH   = 3'd6;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_OOM      = 2'd1;
    localparam status_t STATUS_ORDER    = 2'd2;
    localparam status_t STATUS_REC_FULL = 2'd3;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

@@ rtl/double_ended_stack_allocator.sv @@
// Double-ended stack allocator: one request per transfer on the input channel,
// one result transfer per request; each request is captured with the record
// memory read, then executed and committed once the output register can take
// the result, and the next request is taken as soon as the previous one has
// committed, so a new request is never accepted while one is still in flight.
// A finished result waits in the output register without blocking the next
// request's capture. arena_size (cfg_data) takes effect at the next top reset;
// values above the arena maximum act as the maximum. No clearing pass after reset.
// Depends on desa_pkg, desa_ctrl and desa_datapath.
module double_ended_stack_allocator #(
    parameter int HEADER_BYTES = desa_pkg::HEADER_BYTES,
    parameter int MAX_BLOCKS   = desa_pkg::MAX_BLOCKS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [desa_pkg::KW-1:0]   kind,
    input  logic [desa_pkg::FW-1:0]   request_size,
    input  logic [desa_pkg::AW-1:0]   align_log2,
    input  logic [desa_pkg::FW-1:0]   block_address,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [desa_pkg::SW-1:0]   status,
    output logic [desa_pkg::FW-1:0]   result_address,
    output logic [desa_pkg::FW-1:0]   free_bytes,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [desa_pkg::FW-1:0]   cfg_data
);

    desa_pkg::cmd_t cmd;
    logic           cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    desa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    desa_datapath #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .request_size   (request_size),
        .align_log2     (align_log2),
        .block_address  (block_address),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .status         (status),
        .result_address (result_address),
        .free_bytes     (free_bytes)
    );

endmodule

@@ rtl/desa_ctrl.sv @@
// Controller of the double-ended stack allocator: request sequencing and
// result handshake. Depends on desa_pkg and the assertion macro header.
`include "double_ended_stack_allocator_assert.svh"

module desa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           cfg_ready,
    output desa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `DESA_ASSERT_NXT(a_capture_exec, clk, rst_n, cmd.capture, state_reg == ST_EXEC)
    `DESA_ASSERT_IMP(a_commit_slot, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    `DESA_ASSERT_NXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_reg && in_ready)

endmodule

@@ rtl/desa_datapath.sv @@
// Datapath of the double-ended stack allocator: marks, counts, record
// memories, allocation arithmetic and result registers. Depends on desa_pkg.
module desa_datapath #(
    parameter int HEADER_BYTES = desa_pkg::HEADER_BYTES,
    parameter int MAX_BLOCKS   = desa_pkg::MAX_BLOCKS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  desa_pkg::cmd_t            cmd,
    input  logic [desa_pkg::KW-1:0]   kind,
    input  logic [desa_pkg::FW-1:0]   request_size,
    input  logic [desa_pkg::AW-1:0]   align_log2,
    input  logic [desa_pkg::FW-1:0]   block_address,
    input  logic                      cfg_we,
    input  logic [desa_pkg::FW-1:0]   cfg_data,
    output logic [desa_pkg::SW-1:0]   status,
    output logic [desa_pkg::FW-1:0]   result_address,
    output logic [desa_pkg::FW-1:0]   free_bytes
);

    localparam int FW = desa_pkg::FW;
    localparam int WW = desa_pkg::WW;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [FW-1:0] ARENA_MAX = FW'(desa_pkg::ARENA_BYTES);
    localparam logic [WW-1:0] HDR       = WW'(HEADER_BYTES);

    // captured request
    desa_pkg::kind_t    kind_reg;
    logic [FW-1:0]      size_reg;
    logic [desa_pkg::AW-1:0] alog_reg;
    logic [FW-1:0]      addr_reg;

    logic [FW-1:0] arena_size_reg;
    logic [FW-1:0] bm_reg, bm_next, blh_reg, blh_next;
    logic [FW-1:0] tm_reg, tm_next, tlh_reg, tlh_next;
    logic [CW-1:0] bcnt_reg, bcnt_next, tcnt_reg, tcnt_next;

    logic [2*FW-1:0] bmem [MAX_BLOCKS];
    logic [2*FW-1:0] tmem [MAX_BLOCKS];
    logic [2*FW-1:0] brd_reg, trd_reg;

    desa_pkg::status_t status_reg, status_next;
    logic [FW-1:0]     result_reg, result_next;
    logic [FW-1:0]     free_reg, free_next;

    logic [CW-1:0] bcnt_dec, tcnt_dec;
    logic [WW-1:0] align_mask, bm_w, tm_w, size_w, addr_w;
    logic [WW-1:0] aligned, b_end, t_data, t_hdr, t_end;
    logic          b_oom, b_full, t_oom, t_full, b_bad, t_bad;
    logic          b_push, t_push;
    logic [FW-1:0] eff_arena;

    assign bcnt_dec = bcnt_reg - CW'(1);
    assign tcnt_dec = tcnt_reg - CW'(1);

    assign align_mask = ~((WW'(1) << alog_reg) - WW'(1));
    assign bm_w   = WW'(bm_reg);
    assign tm_w   = WW'(tm_reg);
    assign size_w = WW'(size_reg);
    assign addr_w = WW'(addr_reg);

    assign aligned = (bm_w + ~align_mask) & align_mask;
    assign b_end   = aligned + HDR + size_w;
    assign b_oom   = b_end > tm_w;
    assign b_full  = bcnt_reg >= CW'(MAX_BLOCKS);

    assign t_data = (tm_w - size_w) & align_mask;
    assign t_hdr  = t_data - HDR;
    assign t_oom  = (size_w + HDR > tm_w) || (t_data < HDR) || (t_hdr < bm_w);
    assign t_full = tcnt_reg >= CW'(MAX_BLOCKS);
    assign t_end  = WW'(tlh_reg) + HDR + WW'(trd_reg[FW-1:0]);

    assign b_bad = (bcnt_reg == '0) || (addr_w < HDR) || ((addr_w - HDR) != WW'(blh_reg));
    assign t_bad = (tcnt_reg == '0) || (addr_w < HDR) || ((addr_w - HDR) != WW'(tlh_reg));

    assign eff_arena = (arena_size_reg > ARENA_MAX) ? ARENA_MAX : arena_size_reg;

    assign b_push = cmd.commit && (kind_reg == desa_pkg::KIND_ALLOC_BOTTOM) && !b_oom && !b_full;
    assign t_push = cmd.commit && (kind_reg == desa_pkg::KIND_ALLOC_TOP) && !t_oom && !t_full;

    always_comb
    begin
        bm_next     = bm_reg;
        blh_next    = blh_reg;
        tm_next     = tm_reg;
        tlh_next    = tlh_reg;
        bcnt_next   = bcnt_reg;
        tcnt_next   = tcnt_reg;
        status_next = desa_pkg::STATUS_OK;
        result_next = '0;
        case (kind_reg)
            desa_pkg::KIND_ALLOC_BOTTOM:
            begin
                if (b_oom)
                    status_next = desa_pkg::STATUS_OOM;
                else if (b_full)
                    status_next = desa_pkg::STATUS_REC_FULL;
                else
                begin
                    bcnt_next   = bcnt_reg + CW'(1);
                    blh_next    = aligned[FW-1:0];
                    bm_next     = b_end[FW-1:0];
                    result_next = FW'(aligned + HDR);
                end
            end
            desa_pkg::KIND_ALLOC_TOP:
            begin
                if (t_oom)
                    status_next = desa_pkg::STATUS_OOM;
                else if (t_full)
                    status_next = desa_pkg::STATUS_REC_FULL;
                else
                begin
                    tcnt_next   = tcnt_reg + CW'(1);
                    tlh_next    = t_hdr[FW-1:0];
                    tm_next     = t_hdr[FW-1:0];
                    result_next = t_data[FW-1:0];
                end
            end
            desa_pkg::KIND_FREE_BOTTOM:
            begin
                if (addr_reg != '0)
                begin
                    if (b_bad)
                        status_next = desa_pkg::STATUS_ORDER;
                    else
                    begin
                        bcnt_next = bcnt_dec;
                        bm_next   = blh_reg;
                        blh_next  = brd_reg[2*FW-1:FW];
                    end
                end
            end
            desa_pkg::KIND_FREE_TOP:
            begin
                if (addr_reg != '0)
                begin
                    if (t_bad)
                        status_next = desa_pkg::STATUS_ORDER;
                    else
                    begin
                        tcnt_next = tcnt_dec;
                        tm_next   = t_end[FW-1:0];
                        tlh_next  = trd_reg[2*FW-1:FW];
                    end
                end
            end
            desa_pkg::KIND_RESET_BOTTOM:
            begin
                bm_next   = '0;
                blh_next  = '0;
                bcnt_next = '0;
            end
            desa_pkg::KIND_RESET_TOP:
            begin
                tm_next   = eff_arena;
                tlh_next  = eff_arena;
                tcnt_next = '0;
            end
            desa_pkg::KIND_RESET_BOTH:
            begin
                bm_next   = '0;
                blh_next  = '0;
                bcnt_next = '0;
                tm_next   = eff_arena;
                tlh_next  = eff_arena;
                tcnt_next = '0;
            end
            default:
            begin
                status_next = desa_pkg::STATUS_OK;
            end
        endcase
        free_next = (tm_next > bm_next) ? (tm_next - bm_next) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            size_reg <= request_size;
            alog_reg <= align_log2;
            addr_reg <= block_address;
            brd_reg  <= bmem[bcnt_dec[IW-1:0]];
            trd_reg  <= tmem[tcnt_dec[IW-1:0]];
        end
        if (b_push)
            bmem[bcnt_reg[IW-1:0]] <= {blh_reg, size_reg};
        if (t_push)
            tmem[tcnt_reg[IW-1:0]] <= {tlh_reg, size_reg};
        if (cmd.commit)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
            free_reg   <= free_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_size_reg <= FW'(65536);
            bm_reg         <= '0;
            blh_reg        <= '0;
            tm_reg         <= ARENA_MAX;
            tlh_reg        <= ARENA_MAX;
            bcnt_reg       <= '0;
            tcnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                arena_size_reg <= cfg_data;
            if (cmd.commit)
            begin
                bm_reg   <= bm_next;
                blh_reg  <= blh_next;
                tm_reg   <= tm_next;
                tlh_reg  <= tlh_next;
                bcnt_reg <= bcnt_next;
                tcnt_reg <= tcnt_next;
            end
        end
    end

    assign status         = status_reg;
    assign result_address = result_reg;
    assign free_bytes     = free_reg;

endmodule
